>>> rtl/dqr_pkg.sv
// package: beat types, dns header constants and answer record table for the redirect responder
package dqr_pkg;

   // one request beat: one byte of the query datagram
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // one response beat: one byte of the reply or an end marker
   typedef struct packed {
      logic [7:0] reply_byte;
      logic       end_of_reply;
      logic       discard;
   } rsp_type;

   // what the parser makes of one query byte
   typedef struct packed {
      logic       emit;
      logic [7:0] out_byte;
      logic       last;
      logic       discard;
   } step_type;

   localparam int unsigned HDR_LEN    = 12;
   localparam int unsigned ANSWER_LEN = 16;

   localparam logic [7:0]  PTR_MASK  = 8'hC0;
   localparam logic [15:0] FLAGS_OUT = 16'h8580;
   localparam logic [7:0]  TTL_SECS  = 8'd60;

   // header byte offsets
   localparam int unsigned POS_ID_HI    = 0;
   localparam int unsigned POS_ID_LO    = 1;
   localparam int unsigned POS_FLAGS_HI = 2;
   localparam int unsigned POS_FLAGS_LO = 3;
   localparam int unsigned POS_QD_HI    = 4;
   localparam int unsigned POS_QD_LO    = 5;
   localparam int unsigned POS_AN_LO    = 7;

   // answer record byte offsets
   localparam logic [3:0] ANS_PTR_HI    = 4'd0;
   localparam logic [3:0] ANS_PTR_LO    = 4'd1;
   localparam logic [3:0] ANS_TYPE_LO   = 4'd3;
   localparam logic [3:0] ANS_CLASS_LO  = 4'd5;
   localparam logic [3:0] ANS_TTL_LO    = 4'd9;
   localparam logic [3:0] ANS_RDLEN_LO  = 4'd11;
   localparam logic [3:0] ANS_ADDR_0    = 4'd12;
   localparam logic [3:0] ANS_ADDR_1    = 4'd13;
   localparam logic [3:0] ANS_ADDR_2    = 4'd14;
   localparam logic [3:0] ANS_ADDR_3    = 4'd15;
   localparam logic [3:0] ANS_LAST      = 4'd15;

   // byte of the fixed A record: pointer to offset 12, type 1, class 1, ttl, rdlength 4, address
   function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
      logic [7:0] b;
      case (idx)
         ANS_PTR_HI:   b = PTR_MASK;
         ANS_PTR_LO:   b = 8'(HDR_LEN);
         ANS_TYPE_LO:  b = 8'd1;
         ANS_CLASS_LO: b = 8'd1;
         ANS_TTL_LO:   b = TTL_SECS;
         ANS_RDLEN_LO: b = 8'd4;
         ANS_ADDR_0:   b = addr[31:24];
         ANS_ADDR_1:   b = addr[23:16];
         ANS_ADDR_2:   b = addr[15:8];
         ANS_ADDR_3:   b = addr[7:0];
         default:      b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/dns_query_redirect_responder.sv
// module: top level of the dns redirect responder with input stage, answer sequencer, output register
// Usage:
//  req channel carries one query byte per beat (data_byte, last_byte marks the final byte).
//  rsp channel returns the reply byte by byte; end_of_reply marks the final beat of a
//  datagram and discard on that beat tells the sender to drop the whole reply.
//  csr_wr_en / csr_wr_data load the redirect address; write it only while the block is idle.
//  A byte passes the input register, then the output register, on its way to rsp.
//  Throughput: one byte per cycle through the parse logic while rsp_ready is high and no answer plays out.
//  After the final byte of an accepted query the 16-byte A record follows at one beat
//  per cycle while rsp_ready is high; the input register takes at most one more byte
//  and then req_ready stays low until the record has played out.
//  Reset clears the parse state, the redirect address and all valid flags.
//  When rsp_ready is low the output register holds its beat; the input register still takes
//  bytes until it holds one that produces output, and further bytes wait on req_ready.
module dns_query_redirect_responder #(
   parameter int unsigned BUF_BYTES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dqr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqr_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   logic             in_valid_ff;
   dqr_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   dqr_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             ans_active_ff, ans_active_in;
   logic [3:0]       ans_idx_ff, ans_idx_in;
   logic [31:0]      addr_ff;

   dqr_pkg::step_type st;
   logic              out_free;
   logic              produces;
   logic              in_adv;

   dqr_parser #(.BUF_BYTES(BUF_BYTES)) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (in_adv),
      .in_beat (in_data_ff),
      .result  (st)
   );

   // handshake control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign produces  = st.emit || st.last;
   assign in_adv    = in_valid_ff && !ans_active_ff && (!produces || out_free);
   assign req_ready = !in_valid_ff || in_adv;

   // output register load and answer sequencing
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ans_active_in = ans_active_ff;
      ans_idx_in    = ans_idx_ff;
      if (ans_active_ff) begin
         if (out_free) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.reply_byte   = dqr_pkg::answer_byte(ans_idx_ff, addr_ff);
            rsp_data_in.end_of_reply = (ans_idx_ff == dqr_pkg::ANS_LAST);
            rsp_data_in.discard      = 1'b0;
            ans_idx_in               = ans_idx_ff + 4'd1;
            if (ans_idx_ff == dqr_pkg::ANS_LAST) ans_active_in = 1'b0;
         end
      end else if (in_adv && produces) begin
         rsp_valid_in = 1'b1;
         if (st.emit) begin
            rsp_data_in.reply_byte   = st.out_byte;
            rsp_data_in.end_of_reply = st.last && st.discard;
            rsp_data_in.discard      = st.last && st.discard;
            if (st.last && !st.discard) begin
               ans_active_in = 1'b1;
               ans_idx_in    = dqr_pkg::ANS_PTR_HI;
            end
         end else if (st.discard) begin
            // bare end marker
            rsp_data_in.reply_byte   = 8'h00;
            rsp_data_in.end_of_reply = 1'b1;
            rsp_data_in.discard      = 1'b1;
         end else begin
            // last byte dropped: answer starts right away
            rsp_data_in.reply_byte   = dqr_pkg::answer_byte(dqr_pkg::ANS_PTR_HI, addr_ff);
            rsp_data_in.end_of_reply = 1'b0;
            rsp_data_in.discard      = 1'b0;
            ans_active_in            = 1'b1;
            ans_idx_in               = dqr_pkg::ANS_PTR_LO;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ans_active_ff <= 1'b0;
         addr_ff       <= '0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         rsp_valid_ff  <= rsp_valid_in;
         ans_active_ff <= ans_active_in;
         if (csr_wr_en) addr_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_payload;
      rsp_data_ff <= rsp_data_in;
      ans_idx_ff  <= ans_idx_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // no query byte moves on while the answer record plays out
   a_no_adv_in_answer: assert property (@(posedge clock) disable iff (reset)
      ans_active_ff |-> !in_adv)
      else $error("query byte advanced during answer record");

   // a discard beat always closes the datagram
   a_discard_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.discard |-> rsp_data_ff.end_of_reply)
      else $error("discard without end of reply");

   // the last answer byte ends the sequence and carries the end mark
   a_answer_end: assert property (@(posedge clock) disable iff (reset)
      ans_active_ff && out_free && ans_idx_ff == dqr_pkg::ANS_LAST
      |=> !ans_active_ff && rsp_valid_ff && rsp_data_ff.end_of_reply
          && !rsp_data_ff.discard)
      else $error("answer record did not end properly");

endmodule

>>> rtl/dqr_parser.sv
// module: per-datagram parse state, header rewrite, question name walk and discard decision
module dqr_parser #(
   parameter int unsigned BUF_BYTES = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  dqr_pkg::req_type  in_beat,
   output dqr_pkg::step_type result
);

   localparam int unsigned PW = $clog2(BUF_BYTES + 1);
   localparam int unsigned LW = $clog2(BUF_BYTES + 257);

   logic [PW-1:0] pos_ff, pos_in;
   logic [LW-1:0] nlp_ff, nlp_in;
   logic [LW-1:0] rlen_ff, rlen_in;
   logic          name_done_ff, name_done_in;
   logic          qr_ff, qr_in;
   logic          qd_ff, qd_in;

   logic [7:0]    b;
   logic [7:0]    o;
   logic          emit;
   logic          disc;
   logic [LW-1:0] p_ext;
   logic [LW:0]   rlen_end;

   assign b     = in_beat.data_byte;
   assign p_ext = LW'(pos_ff);

   // per-byte next state and output byte
   always_comb begin
      pos_in       = pos_ff;
      nlp_in       = nlp_ff;
      rlen_in      = rlen_ff;
      name_done_in = name_done_ff;
      qr_in        = qr_ff;
      qd_in        = qd_ff;
      emit         = 1'b0;
      o            = b;
      if (pos_ff < PW'(BUF_BYTES)) begin
         pos_in = pos_ff + PW'(1);
         if (pos_ff < PW'(dqr_pkg::HDR_LEN)) begin
            emit = 1'b1;
            case (pos_ff)
               PW'(dqr_pkg::POS_ID_HI), PW'(dqr_pkg::POS_ID_LO): o = b;
               PW'(dqr_pkg::POS_FLAGS_HI): begin
                  qr_in = b[7];
                  o     = dqr_pkg::FLAGS_OUT[15:8];
               end
               PW'(dqr_pkg::POS_FLAGS_LO): o = dqr_pkg::FLAGS_OUT[7:0];
               PW'(dqr_pkg::POS_QD_HI), PW'(dqr_pkg::POS_QD_LO): begin
                  if (b != 8'h00) qd_in = 1'b1;
               end
               PW'(dqr_pkg::POS_AN_LO): o = 8'd1;
               default: o = 8'h00;
            endcase
         end else begin
            // walk the question name one label at a time
            if (!name_done_ff && p_ext == nlp_ff) begin
               if (b == 8'h00) begin
                  name_done_in = 1'b1;
                  rlen_in      = p_ext + LW'(5);
               end else if ((b & dqr_pkg::PTR_MASK) == dqr_pkg::PTR_MASK) begin
                  name_done_in = 1'b1;
                  rlen_in      = p_ext + LW'(6);
               end else begin
                  nlp_in = p_ext + LW'(1) + LW'(b);
               end
            end
            emit = !name_done_in || (p_ext < rlen_in);
         end
      end
   end

   // discard decision for the final byte
   assign rlen_end = {1'b0, rlen_in} + (LW+1)'(dqr_pkg::ANSWER_LEN);
   assign disc = (pos_in < PW'(dqr_pkg::HDR_LEN)) || qr_in || !qd_in || !name_done_in
              || (rlen_in > LW'(pos_in)) || (rlen_end > (LW+1)'(BUF_BYTES));

   assign result.emit     = emit;
   assign result.out_byte = o;
   assign result.last     = in_beat.last_byte;
   assign result.discard  = disc;

   // state update, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         nlp_ff       <= LW'(dqr_pkg::HDR_LEN);
         rlen_ff      <= '0;
         name_done_ff <= 1'b0;
         qr_ff        <= 1'b0;
         qd_ff        <= 1'b0;
      end else if (step) begin
         if (in_beat.last_byte) begin
            pos_ff       <= '0;
            nlp_ff       <= LW'(dqr_pkg::HDR_LEN);
            rlen_ff      <= '0;
            name_done_ff <= 1'b0;
            qr_ff        <= 1'b0;
            qd_ff        <= 1'b0;
         end else begin
            pos_ff       <= pos_in;
            nlp_ff       <= nlp_in;
            rlen_ff      <= rlen_in;
            name_done_ff <= name_done_in;
            qr_ff        <= qr_in;
            qd_ff        <= qd_in;
         end
      end
   end

endmodule
